// ----- design/saib_pkg.sv -----
`timescale 1ns / 1ps
// Package for the suffix automaton builder: sizes, controller states,
// datapath operations and the command and status structs. No dependencies.
package saib_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 256;  // a power of two, so a symbol is reduced by masking
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int SYM_W     = $clog2(ALPHABET);
  localparam int TT_DEPTH  = MAX_NODES * ALPHABET;
  localparam int TT_AW     = NODE_W + SYM_W;
  localparam int COPY_W    = SYM_W + 1;
  localparam logic [7:0] STOP_SYMBOL = 8'd35;
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [CNT_W-1:0]  NODES_AT_RESET = CNT_W'(2);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_A_START, ST_A_ALLOC, ST_W_RD, ST_W_CHK, ST_L_PREV,
    ST_L_CHK, ST_MID_META, ST_COPY, ST_R_RD, ST_R_CHK, ST_FIN_NEXT, ST_END,
    ST_DONE
  } saib_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_LOAD_OVF, OP_START_APP, OP_ALLOC_FRESH,
    OP_WALK_RD, OP_WALK_SET, OP_LINK_ROOT, OP_RD_LEN_NEXT, OP_RD_LEN_PREV,
    OP_LINK_NEXT, OP_ALLOC_MID, OP_MID_META, OP_COPY, OP_REDIR_SET,
    OP_FIN_FRESH, OP_FIN_NEXT, OP_APP_END, OP_LOAD_OUT
  } saib_op_e;

  typedef struct packed {
    saib_op_e op;
  } saib_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ovf;
    logic prev_zero;
    logic edge_zero;
    logic edge_is_next;
    logic len_eq;
    logic copy_done;
    logic pend;
    logic out_free;
  } saib_status_t;

endpackage

// ----- design/saib_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the suffix automaton builder (input and result).
// Depends on saib_pkg for the field widths.
interface saib_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] symbol;
  modport source (output valid, output opcode, output symbol, input ready);
  modport sink (input valid, input opcode, input symbol, output ready);
endinterface

interface saib_out_if;
  logic                        valid;
  logic                        ready;
  logic [saib_pkg::NODE_W-1:0] fresh_node;
  logic [saib_pkg::NODE_W-1:0] suffix_link;
  logic                        cloned;
  logic [saib_pkg::NODE_W-1:0] clone_node;
  logic [saib_pkg::CNT_W-1:0]  node_count;
  logic                        overflow;
  modport source (output valid, output fresh_node, output suffix_link, output cloned,
                  output clone_node, output node_count, output overflow, input ready);
  modport sink (input valid, input fresh_node, input suffix_link, input cloned,
                input clone_node, input node_count, input overflow, output ready);
endinterface

// ----- design/saib_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module saib_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- design/saib_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the suffix automaton builder: sequences the clearing pass,
// the suffix-link walks, the split and the result hand-off. Uses saib_pkg.
module saib_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  saib_pkg::saib_status_t status_i,
  output saib_pkg::saib_cmd_t    cmd_o
);
  saib_pkg::saib_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saib_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = saib_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      saib_pkg::ST_CLEAR: begin
        cmd_o.op = saib_pkg::OP_CLEAR;
        if (status_i.clr_last) begin
          state_d = saib_pkg::ST_IDLE;
        end
      end
      saib_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.ovf) begin
            cmd_o.op = saib_pkg::OP_LOAD_OVF;
            state_d  = saib_pkg::ST_DONE;
          end else begin
            cmd_o.op = saib_pkg::OP_LOAD;
            state_d  = saib_pkg::ST_A_START;
          end
        end
      end
      saib_pkg::ST_A_START: begin
        cmd_o.op = saib_pkg::OP_START_APP;
        state_d  = saib_pkg::ST_A_ALLOC;
      end
      saib_pkg::ST_A_ALLOC: begin
        cmd_o.op = saib_pkg::OP_ALLOC_FRESH;
        state_d  = saib_pkg::ST_W_RD;
      end
      saib_pkg::ST_W_RD: begin
        cmd_o.op = saib_pkg::OP_WALK_RD;
        state_d  = saib_pkg::ST_W_CHK;
      end
      saib_pkg::ST_W_CHK: begin
        priority if (status_i.prev_zero) begin
          cmd_o.op = saib_pkg::OP_LINK_ROOT;
          state_d  = saib_pkg::ST_END;
        end else if (status_i.edge_zero) begin
          cmd_o.op = saib_pkg::OP_WALK_SET;
          state_d  = saib_pkg::ST_W_RD;
        end else begin
          cmd_o.op = saib_pkg::OP_RD_LEN_NEXT;
          state_d  = saib_pkg::ST_L_PREV;
        end
      end
      saib_pkg::ST_L_PREV: begin
        cmd_o.op = saib_pkg::OP_RD_LEN_PREV;
        state_d  = saib_pkg::ST_L_CHK;
      end
      saib_pkg::ST_L_CHK: begin
        if (status_i.len_eq) begin
          cmd_o.op = saib_pkg::OP_LINK_NEXT;
          state_d  = saib_pkg::ST_END;
        end else begin
          cmd_o.op = saib_pkg::OP_ALLOC_MID;
          state_d  = saib_pkg::ST_MID_META;
        end
      end
      saib_pkg::ST_MID_META: begin
        cmd_o.op = saib_pkg::OP_MID_META;
        state_d  = saib_pkg::ST_COPY;
      end
      saib_pkg::ST_COPY: begin
        cmd_o.op = saib_pkg::OP_COPY;
        if (status_i.copy_done) begin
          state_d = saib_pkg::ST_R_RD;
        end
      end
      saib_pkg::ST_R_RD: begin
        cmd_o.op = saib_pkg::OP_WALK_RD;
        state_d  = saib_pkg::ST_R_CHK;
      end
      saib_pkg::ST_R_CHK: begin
        if (!status_i.prev_zero && status_i.edge_is_next) begin
          cmd_o.op = saib_pkg::OP_REDIR_SET;
          state_d  = saib_pkg::ST_R_RD;
        end else begin
          cmd_o.op = saib_pkg::OP_FIN_FRESH;
          state_d  = saib_pkg::ST_FIN_NEXT;
        end
      end
      saib_pkg::ST_FIN_NEXT: begin
        cmd_o.op = saib_pkg::OP_FIN_NEXT;
        state_d  = saib_pkg::ST_END;
      end
      saib_pkg::ST_END: begin
        cmd_o.op = saib_pkg::OP_APP_END;
        state_d  = status_i.pend ? saib_pkg::ST_A_START : saib_pkg::ST_DONE;
      end
      saib_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = saib_pkg::OP_LOAD_OUT;
          state_d  = saib_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = saib_pkg::ST_CLEAR;
      end
    endcase
  end

  // A copy of the edge row always ends in the redirect walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == saib_pkg::ST_COPY |=> state_q == saib_pkg::ST_COPY ||
                                     state_q == saib_pkg::ST_R_RD)
    else $error("copy left to an unexpected state");
  // Items are only taken once the clearing pass is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q != saib_pkg::ST_CLEAR && !status_i.pend)
    else $error("ready while busy");
  // The split branch is only entered when the lengths differ.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == saib_pkg::ST_MID_META |-> $past(state_q) == saib_pkg::ST_L_CHK)
    else $error("clone metadata without length check");
endmodule

// ----- design/saib_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the suffix automaton builder: node store RAMs, walk registers
// and the result register. Uses saib_pkg and saib_ram.
module saib_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  saib_pkg::saib_cmd_t           cmd_i,
  output saib_pkg::saib_status_t        status_o,
  input  logic                          in_opcode_i,
  input  logic [7:0]                    in_symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [saib_pkg::NODE_W-1:0]   out_fresh_node_o,
  output logic [saib_pkg::NODE_W-1:0]   out_suffix_link_o,
  output logic                          out_cloned_o,
  output logic [saib_pkg::NODE_W-1:0]   out_clone_node_o,
  output logic [saib_pkg::CNT_W-1:0]    out_node_count_o,
  output logic                          out_overflow_o
);
  localparam int NW = saib_pkg::NODE_W;
  localparam int SW = saib_pkg::SYM_W;
  localparam int CW = saib_pkg::CNT_W;
  localparam int KW = saib_pkg::COPY_W;
  localparam int AW = saib_pkg::TT_AW;

  saib_pkg::saib_op_e op;

  logic [AW-1:0] clr_q;
  logic [NW-1:0] last_q, prev_q, fresh_q, next_q, mid_q, len_next_q, len_prev_q;
  logic [CW-1:0] used_q;
  logic [SW-1:0] sym_q, sym_in_q;
  logic          pend_q;
  logic [KW-1:0] k_q;
  logic [NW-1:0] res_new_q, res_link_q, res_clone_q;
  logic          res_ovf_q, out_valid_q, out_valid_d;
  logic [NW-1:0] out_fresh_q, out_link_q, out_clone_q;
  logic [CW-1:0] out_count_q;
  logic          out_ovf_q;

  logic                       tt_we, len_we, lnk_we;
  logic [AW-1:0]              tt_wa, tt_ra;
  logic [NW-1:0]              tt_wd, tt_rd, len_wa, len_ra, len_wd, len_rd;
  logic [NW-1:0]              lnk_wa, lnk_ra, lnk_wd, lnk_rd;
  logic [CW:0]                need_sum;
  logic [NW-1:0]              used_node;
  logic [KW-1:0]              k_prev;

  assign op        = cmd_i.op;
  assign used_node = used_q[NW-1:0];
  assign k_prev    = k_q - KW'(1);
  assign need_sum  = {1'b0, used_q} + (in_opcode_i ? (CW+1)'(4) : (CW+1)'(2));

  assign status_o.clr_last     = &clr_q;
  assign status_o.ovf          = need_sum > (CW+1)'(saib_pkg::MAX_NODES);
  assign status_o.prev_zero    = prev_q == '0;
  assign status_o.edge_zero    = tt_rd == '0;
  assign status_o.edge_is_next = tt_rd == next_q;
  assign status_o.len_eq       = len_next_q == len_rd + NW'(1);
  assign status_o.copy_done    = k_q == KW'(saib_pkg::ALPHABET);
  assign status_o.pend         = pend_q;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  // RAM port selection by operation.
  always_comb begin
    tt_we  = 1'b0;
    tt_wa  = '0;
    tt_wd  = '0;
    tt_ra  = '0;
    len_we = 1'b0;
    len_wa = '0;
    len_wd = '0;
    len_ra = '0;
    lnk_we = 1'b0;
    lnk_wa = '0;
    lnk_wd = '0;
    lnk_ra = '0;
    unique case (op)
      saib_pkg::OP_CLEAR: begin
        tt_we  = 1'b1;
        tt_wa  = clr_q;
        len_we = 1'b1;
        len_wa = clr_q[NW-1:0];
        lnk_we = 1'b1;
        lnk_wa = clr_q[NW-1:0];
      end
      saib_pkg::OP_START_APP: len_ra = last_q;
      saib_pkg::OP_ALLOC_FRESH: begin
        len_we = 1'b1;
        len_wa = used_node;
        len_wd = len_rd + NW'(1);
      end
      saib_pkg::OP_WALK_RD: begin
        tt_ra  = {prev_q, sym_q};
        lnk_ra = prev_q;
      end
      saib_pkg::OP_WALK_SET: begin
        tt_we = 1'b1;
        tt_wa = {prev_q, sym_q};
        tt_wd = fresh_q;
      end
      saib_pkg::OP_LINK_ROOT: begin
        lnk_we = 1'b1;
        lnk_wa = fresh_q;
        lnk_wd = saib_pkg::ROOT_NODE;
      end
      saib_pkg::OP_RD_LEN_NEXT: len_ra = tt_rd;
      saib_pkg::OP_RD_LEN_PREV: len_ra = prev_q;
      saib_pkg::OP_LINK_NEXT: begin
        lnk_we = 1'b1;
        lnk_wa = fresh_q;
        lnk_wd = next_q;
      end
      saib_pkg::OP_ALLOC_MID: lnk_ra = next_q;
      saib_pkg::OP_MID_META: begin
        lnk_we = 1'b1;
        lnk_wa = mid_q;
        lnk_wd = lnk_rd;
        len_we = 1'b1;
        len_wa = mid_q;
        len_wd = len_prev_q + NW'(1);
      end
      saib_pkg::OP_COPY: begin
        // Read entry k of the split node while entry k-1 lands in the clone.
        tt_ra = {next_q, k_q[SW-1:0]};
        tt_we = k_q != '0;
        tt_wa = {mid_q, k_prev[SW-1:0]};
        tt_wd = tt_rd;
      end
      saib_pkg::OP_REDIR_SET: begin
        tt_we = 1'b1;
        tt_wa = {prev_q, sym_q};
        tt_wd = mid_q;
      end
      saib_pkg::OP_FIN_FRESH: begin
        lnk_we = 1'b1;
        lnk_wa = fresh_q;
        lnk_wd = mid_q;
      end
      saib_pkg::OP_FIN_NEXT: begin
        lnk_we = 1'b1;
        lnk_wa = next_q;
        lnk_wd = mid_q;
      end
      default: begin
      end
    endcase
  end

  // A waiting result leaves on its transaction; a newly loaded one takes its place.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (op == saib_pkg::OP_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      last_q      <= saib_pkg::ROOT_NODE;
      used_q      <= saib_pkg::NODES_AT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (op)
        saib_pkg::OP_CLEAR:       clr_q <= clr_q + AW'(1);
        saib_pkg::OP_LOAD:        pend_q <= in_opcode_i;
        saib_pkg::OP_ALLOC_FRESH: begin
          last_q <= used_node;
          used_q <= used_q + CW'(1);
        end
        saib_pkg::OP_ALLOC_MID:   used_q <= used_q + CW'(1);
        saib_pkg::OP_APP_END:     pend_q <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op)
      saib_pkg::OP_LOAD: begin
        sym_q     <= in_opcode_i ? saib_pkg::STOP_SYMBOL[SW-1:0] : in_symbol_i[SW-1:0];
        sym_in_q  <= in_symbol_i[SW-1:0];
        res_ovf_q <= 1'b0;
      end
      saib_pkg::OP_LOAD_OVF: begin
        res_new_q   <= '0;
        res_link_q  <= '0;
        res_clone_q <= '0;
        res_ovf_q   <= 1'b1;
      end
      saib_pkg::OP_START_APP: prev_q <= last_q;
      saib_pkg::OP_ALLOC_FRESH: begin
        fresh_q     <= used_node;
        res_new_q   <= used_node;
        res_clone_q <= '0;
      end
      saib_pkg::OP_WALK_SET, saib_pkg::OP_REDIR_SET: prev_q <= lnk_rd;
      saib_pkg::OP_LINK_ROOT: res_link_q <= saib_pkg::ROOT_NODE;
      saib_pkg::OP_RD_LEN_NEXT: next_q <= tt_rd;
      saib_pkg::OP_RD_LEN_PREV: len_next_q <= len_rd;
      saib_pkg::OP_LINK_NEXT: res_link_q <= next_q;
      saib_pkg::OP_ALLOC_MID: begin
        mid_q      <= used_node;
        len_prev_q <= len_rd;
      end
      saib_pkg::OP_MID_META: k_q <= '0;
      saib_pkg::OP_COPY: k_q <= k_q + KW'(1);
      saib_pkg::OP_FIN_FRESH: begin
        res_link_q  <= mid_q;
        res_clone_q <= mid_q;
      end
      saib_pkg::OP_APP_END: begin
        if (pend_q) begin
          sym_q <= sym_in_q;
        end
      end
      saib_pkg::OP_LOAD_OUT: begin
        out_fresh_q <= res_new_q;
        out_link_q  <= res_link_q;
        out_clone_q <= res_clone_q;
        out_count_q <= used_q;
        out_ovf_q   <= res_ovf_q;
      end
      default: begin
      end
    endcase
  end

  saib_ram #(.WIDTH(NW), .DEPTH(saib_pkg::TT_DEPTH)) u_tt_ram (
    .clk_i, .we_i(tt_we), .waddr_i(tt_wa), .wdata_i(tt_wd), .raddr_i(tt_ra), .rdata_o(tt_rd)
  );
  saib_ram #(.WIDTH(NW), .DEPTH(saib_pkg::MAX_NODES)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd), .raddr_i(len_ra),
    .rdata_o(len_rd)
  );
  saib_ram #(.WIDTH(NW), .DEPTH(saib_pkg::MAX_NODES)) u_lnk_ram (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd), .raddr_i(lnk_ra),
    .rdata_o(lnk_rd)
  );

  assign out_valid_o       = out_valid_q;
  assign out_fresh_node_o  = out_fresh_q;
  assign out_suffix_link_o = out_link_q;
  assign out_cloned_o      = out_clone_q != '0;
  assign out_clone_node_o  = out_clone_q;
  assign out_node_count_o  = out_count_q;
  assign out_overflow_o    = out_ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(saib_pkg::MAX_NODES))
    else $error("node store overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, last_q} < used_q)
    else $error("last node not allocated");
  // The clone being filled is always the most recently allocated node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op == saib_pkg::OP_COPY |-> {1'b0, mid_q} == used_q - CW'(1))
    else $error("clone copy into wrong row");
endmodule

// ----- design/suffix_automaton_builder_top.sv -----
`timescale 1ns / 1ps
// Top level of the suffix automaton builder: joins controller and datapath.
// Depends on saib_pkg, saib_if, saib_ctrl, saib_dp (and saib_ram below it).
//
//   channel | dir | payload                                            | handshake
//   in_i    | in  | opcode, symbol                                     | valid/ready
//   out_o   | out | fresh_node, suffix_link, cloned, clone_node,       | valid/ready
//           |     | node_count, overflow                               |
//
// One item at a time: acceptance, then per append a start, an allocation and a suffix-link walk,
// with the edge target's length compared when the walk finds an edge; a split adds the clone
// metadata, the copy of the edge row and the redirected edges. The result hand-off ends the item.
// A start-document item runs two appends. An overflowed item goes straight to the hand-off.
// After reset a clearing pass zeroes the store; no item is taken meanwhile.
// An output register lets the next item in while a result waits; a stalled result holds
// the block before its next hand-off.
module suffix_automaton_builder_top (
  input logic clk_i,
  input logic rst_ni,
  saib_in_if.sink    in_i,
  saib_out_if.source out_o
);
  saib_pkg::saib_cmd_t    cmd;
  saib_pkg::saib_status_t status;

  saib_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .status_i(status),
    .cmd_o(cmd)
  );

  saib_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .status_o(status),
    .in_opcode_i(in_i.opcode),
    .in_symbol_i(in_i.symbol),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_fresh_node_o(out_o.fresh_node),
    .out_suffix_link_o(out_o.suffix_link),
    .out_cloned_o(out_o.cloned),
    .out_clone_node_o(out_o.clone_node),
    .out_node_count_o(out_o.node_count),
    .out_overflow_o(out_o.overflow)
  );
endmodule
